/* hw/rtl/cdrs_pkg.sv */
`timescale 1ns / 1ps

package cdrs_pkg;

  localparam int TRACK_W      = 12;
  localparam int MAX_REQUESTS = 16;
  localparam int SLOTS        = MAX_REQUESTS + 2;
  localparam int CNT_W        = $clog2(SLOTS + 1);
  localparam int DT_W         = TRACK_W + 1;
  localparam int DIST_W       = TRACK_W;
  localparam int SUM_W        = 17;
  localparam int CFG_ADDR_W   = 1;
  localparam int IN_TDATA_W   = ((2 + TRACK_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = TRACK_W + DIST_W + SUM_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  localparam logic [DT_W-1:0] DISK_CAP = DT_W'(1) << TRACK_W;

  typedef logic [TRACK_W-1:0] track_t;

  typedef enum logic [1:0] {
    CMD_ADD     = 2'd0,
    CMD_ADD_RUN = 2'd1,
    CMD_RUN     = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_t;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_DISK_TRACKS = 1'b0,
    REG_START_HEAD  = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_INSERT = 2'd1,
    OP_ROTATE = 2'd2,
    OP_SHIFT  = 2'd3
  } cell_op_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_ADD_ZERO,
    ST_ADD_LAST,
    ST_ROTATE,
    ST_EMIT
  } state_t;

  typedef struct packed {
    cell_op_t         op;
    track_t           ins_val;
    logic [CNT_W-1:0] cnt;
  } cell_ctl_t;

endpackage

/* hw/rtl/cdrs_cell.sv */
`timescale 1ns / 1ps

module cdrs_cell
  import cdrs_pkg::*;
(
  input  logic             clk,
  input  cell_ctl_t        ctl,
  input  logic [CNT_W-1:0] idx,
  input  track_t           left_val,
  input  logic             left_gt,
  input  track_t           right_val,
  input  track_t           wrap_val,
  output track_t           val_o,
  output logic             gt_o
);

  track_t val_r, val_nxt;
  logic   occ;
  logic   tail;

  // A cell beyond the count is empty and counts as larger than any track.
  assign occ   = idx < ctl.cnt;
  assign tail  = (idx + CNT_W'(1)) == ctl.cnt;
  assign gt_o  = !occ || (val_r > ctl.ins_val);
  assign val_o = val_r;

  always_comb begin
    val_nxt = val_r;
    unique case (ctl.op)
      OP_INSERT: begin
        if (gt_o) begin
          val_nxt = left_gt ? left_val : ctl.ins_val;
        end
      end
      OP_ROTATE: val_nxt = tail ? wrap_val : right_val;
      OP_SHIFT:  val_nxt = right_val;
      default:   val_nxt = val_r;
    endcase
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule

/* hw/rtl/cdrs_ctrl.sv */
`timescale 1ns / 1ps

module cdrs_ctrl
  import cdrs_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic [1:0]   in_cmd,
  input  track_t       in_track,
  input  track_t       last_trk,
  input  track_t       start_head,
  input  track_t       head_val,
  output cell_ctl_t    ctl,
  output logic         out_valid,
  input  logic         out_ready,
  output track_t       out_track,
  output logic [DIST_W-1:0] out_dist,
  output logic [SUM_W-1:0]  out_sum,
  output logic         out_last
);

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [CNT_W-1:0]  rot_r, rot_nxt;
  track_t            head_r, head_nxt;
  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic              out_valid_r, out_valid_nxt;
  track_t            out_track_r;
  logic [DIST_W-1:0] out_dist_r;
  logic [SUM_W-1:0]  out_sum_r;
  logic              out_last_r;

  logic              in_acc;
  logic              emit_go;
  logic              room;
  track_t            clamped;
  track_t            head_eff;
  logic [DIST_W-1:0] move_dist;

  assign in_ready = (state_r == ST_LOAD);
  assign in_acc   = in_valid && in_ready;
  assign room     = cnt_r < CNT_W'(MAX_REQUESTS);
  assign clamped  = (in_track > last_trk) ? last_trk : in_track;
  assign emit_go  = (state_r == ST_EMIT) && (!out_valid_r || out_ready);

  // Returning from the upper end to the low tracks is a jump from track 0.
  assign head_eff  = (head_r > start_head && head_val <= start_head) ? '0 : head_r;
  assign move_dist = (head_eff > head_val) ? (head_eff - head_val) : (head_val - head_eff);

  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    rot_nxt     = rot_r;
    head_nxt    = head_r;
    sum_nxt     = sum_r;
    ctl.op      = OP_HOLD;
    ctl.ins_val = clamped;
    ctl.cnt     = cnt_r;
    unique case (state_r)
      ST_LOAD: begin
        if (in_acc) begin
          unique case (cmd_t'(in_cmd))
            CMD_ADD, CMD_ADD_RUN: begin
              if (room) begin
                ctl.op  = OP_INSERT;
                cnt_nxt = cnt_r + CNT_W'(1);
              end
              if (cmd_t'(in_cmd) == CMD_ADD_RUN) begin
                state_nxt = ST_ADD_ZERO;
              end
            end
            CMD_RUN:  state_nxt = ST_ADD_ZERO;
            default:  state_nxt = ST_LOAD;
          endcase
        end
      end
      ST_ADD_ZERO: begin
        ctl.op      = OP_INSERT;
        ctl.ins_val = '0;
        cnt_nxt     = cnt_r + CNT_W'(1);
        rot_nxt     = '0;
        head_nxt    = start_head;
        sum_nxt     = '0;
        state_nxt   = ST_ADD_LAST;
      end
      ST_ADD_LAST: begin
        ctl.op      = OP_INSERT;
        ctl.ins_val = last_trk;
        cnt_nxt     = cnt_r + CNT_W'(1);
        state_nxt   = ST_ROTATE;
      end
      ST_ROTATE: begin
        if (head_val > start_head || rot_r == cnt_r) begin
          state_nxt = ST_EMIT;
        end else begin
          ctl.op  = OP_ROTATE;
          rot_nxt = rot_r + CNT_W'(1);
        end
      end
      ST_EMIT: begin
        if (emit_go) begin
          ctl.op   = OP_SHIFT;
          cnt_nxt  = cnt_r - CNT_W'(1);
          head_nxt = head_val;
          sum_nxt  = sum_r + SUM_W'(move_dist);
          if (cnt_r == CNT_W'(1)) begin
            state_nxt = ST_LOAD;
          end
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  always_comb begin
    if (emit_go) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      cnt_r       <= '0;
      rot_r       <= '0;
      head_r      <= '0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      rot_r       <= rot_nxt;
      head_r      <= head_nxt;
      sum_r       <= sum_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_go) begin
      out_track_r <= head_val;
      out_dist_r  <= move_dist;
      out_sum_r   <= sum_nxt;
      out_last_r  <= (cnt_r == CNT_W'(1));
    end
  end

  assign out_valid = out_valid_r;
  assign out_track = out_track_r;
  assign out_dist  = out_dist_r;
  assign out_sum   = out_sum_r;
  assign out_last  = out_last_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(SLOTS))
    else $error("Cell count exceeds the chain length.");

  a_load_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_LOAD |-> cnt_r <= CNT_W'(MAX_REQUESTS))
    else $error("Too many requests held while loading.");

  a_emit_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_EMIT |-> cnt_r != '0)
    else $error("Emitting from an empty chain.");

  a_rot_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_ROTATE |-> rot_r <= cnt_r)
    else $error("Rotation ran past the set size.");

endmodule

/* hw/rtl/cscan_disk_request_scheduler.sv */
`timescale 1ns / 1ps

// Channel   Direction  Fields (lowest bit up)
// in_*      input      tdata: command[1:0], track[13:2]
// out_*     output     tdata: served_track[11:0], move_distance[23:12],
//                      total_movement[40:24]; tlast: last_served
// cfg_*     input      index 0 disk_tracks, index 1 start_head
//
// Requests are taken one per cycle while the scheduler is loading, and sorted on
// entry by the cell chain. A run inserts track 0 and the last track, then rotates
// the chain by at most the set size to bring the first track above the head to
// the front, then emits one result per cycle while the output register is free.
// Reset clears control state and the configuration registers; cell contents are ignored until written.
// A stalled output holds emission; the next transaction is accepted while
// the final result still waits.

module cscan_disk_request_scheduler
  import cdrs_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // command, track
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // served_track, move_distance, total_movement
  output logic                   out_tlast,
  input  logic                   cfg_we,
  input  logic [CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [DT_W-1:0]        cfg_wdata
);

  logic [DT_W-1:0]   disk_tracks_r;
  track_t            start_head_r;
  logic [DT_W-1:0]   dt_sat;
  track_t            last_trk;
  cell_ctl_t         ctl;
  track_t            cell_val [SLOTS];
  logic              cell_gt  [SLOTS];
  track_t            out_track;
  logic [DIST_W-1:0] out_dist;
  logic [SUM_W-1:0]  out_sum;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      disk_tracks_r <= DT_W'(200);
      start_head_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_addr))
        REG_DISK_TRACKS: disk_tracks_r <= cfg_wdata;
        REG_START_HEAD:  start_head_r  <= cfg_wdata[TRACK_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (disk_tracks_r == '0) begin
      dt_sat = DT_W'(1);
    end else if (disk_tracks_r > DISK_CAP) begin
      dt_sat = DISK_CAP;
    end else begin
      dt_sat = disk_tracks_r;
    end
  end

  assign last_trk = track_t'(dt_sat - DT_W'(1));

  cdrs_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_cmd     (in_tdata[1:0]),
    .in_track   (in_tdata[TRACK_W+1:2]),
    .last_trk   (last_trk),
    .start_head (start_head_r),
    .head_val   (cell_val[0]),
    .ctl        (ctl),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_track  (out_track),
    .out_dist   (out_dist),
    .out_sum    (out_sum),
    .out_last   (out_tlast)
  );

  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    track_t left_val;
    logic   left_gt;
    track_t right_val;

    if (i == 0) begin : g_first
      assign left_val = '0;
      assign left_gt  = 1'b0;
    end else begin : g_mid
      assign left_val = cell_val[i-1];
      assign left_gt  = cell_gt[i-1];
    end

    if (i == SLOTS - 1) begin : g_tail
      assign right_val = '0;
    end else begin : g_body
      assign right_val = cell_val[i+1];
    end

    cdrs_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .idx       (CNT_W'(i)),
      .left_val  (left_val),
      .left_gt   (left_gt),
      .right_val (right_val),
      .wrap_val  (cell_val[0]),
      .val_o     (cell_val[i]),
      .gt_o      (cell_gt[i])
    );
  end

  assign out_tdata = {{(OUT_TDATA_W - OUT_FIELDS_W){1'b0}}, out_sum, out_dist, out_track};

endmodule
